// ===== hdl/sbx_pkg.sv =====
// Shared types and constants for the serial byte exchange receive buffer.
package sbx_pkg;

	// Operation codes of an input item.
	localparam logic OP_EXCHANGE = 1'b0;
	localparam logic OP_POP      = 1'b1;

	// Result sequencing of one exchange: sixteen bit phases, then four terminate words.
	localparam int          PHASE_W        = 5;
	localparam logic [4:0]  LAST_PHASE     = 5'd19;
	localparam int          CLK_POS        = 7;

	// Terminate sequence words and their wait flags, in order of emission.
	localparam logic [7:0] TERM_WORD [4] = '{8'h0F, 8'h8F, 8'h0F, 8'h00};
	localparam logic [3:0] TERM_WAIT      = 4'b1011;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic       op;
		logic [7:0] tx_byte;
		logic [7:0] rx_byte;
		logic       byte_stored;
		logic [7:0] fill_level;
		logic       buffer_empty;
	} sbx_cmd_t;

	// Occupancy report of the command queue.
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} sbx_qstat_t;

endpackage

// ===== hdl/sbx_front.sv =====
// Front end: accepts items, applies the store and pop rules, owns the receive buffer.
module sbx_front #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         tx_byte,
	input  logic               partner_ready_sample,
	input  logic [7:0]         line_samples,
	input  sbx_pkg::sbx_qstat_t qstat,
	output logic               push,
	output sbx_pkg::sbx_cmd_t  push_cmd
);
	import sbx_pkg::*;

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH);

	logic              accept_zero_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W+7:0]  count_ext;
	logic [7:0]        store_q [BUFFER_DEPTH];
	logic [7:0]        rd_data_q;
	logic [QCNT_W:0]   credit_used;
	logic              accept;
	logic              do_pop;
	logic              do_store;

	logic              valid_s1;
	logic              op_s1;
	logic [7:0]        tx_s1;
	logic [7:0]        rx_s1;
	logic              stored_s1;
	logic [7:0]        fill_s1;
	logic              empty_s1;

	// Only take an item when the queue can absorb it together with the one in flight.
	assign credit_used = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, valid_s1};
	assign in_stall    = (credit_used >= (QCNT_W+1)'(QUEUE_DEPTH));
	assign accept      = in_valid && !in_stall;

	// Classify the item against the buffer state.
	assign do_pop   = accept && (op == OP_POP) && (count_q != '0);
	assign do_store = accept && (op == OP_EXCHANGE) && partner_ready_sample
		&& ((line_samples != 8'd0) || accept_zero_q)
		&& (count_q != CNT_W'(BUFFER_DEPTH - 1));

	always_comb begin
		count_nxt = count_q;
		if (do_store) begin
			count_nxt = count_q + 1'b1;
		end else if (do_pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// Reported fill level is the count modulo 256.
	assign count_ext = {8'd0, count_nxt};

	// Configuration register and buffer bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_zero_q <= 1'b0;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				accept_zero_q <= cfg_wr_data;
			end
			if (do_store) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_nxt;
		end
	end

	// Receive buffer memory with a registered read port.
	always_ff @(posedge clk) begin
		if (do_store) begin
			store_q[wr_ptr_q] <= line_samples;
		end
		if (do_pop) begin
			rd_data_q <= store_q[rd_ptr_q];
		end
	end

	// Stage 1 holds the classified item while the buffer read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			tx_s1     <= tx_byte;
			rx_s1     <= line_samples;
			stored_s1 <= do_store;
			fill_s1   <= count_ext[7:0];
			empty_s1  <= (op == OP_POP) && (count_q == '0);
		end
	end

	// Hand the finished command to the queue.
	assign push = valid_s1;

	always_comb begin
		push_cmd              = '0;
		push_cmd.op           = op_s1;
		push_cmd.tx_byte      = tx_s1;
		push_cmd.byte_stored  = stored_s1;
		push_cmd.fill_level   = fill_s1;
		push_cmd.buffer_empty = empty_s1;
		if (op_s1 == OP_POP) begin
			push_cmd.rx_byte = empty_s1 ? 8'd0 : rd_data_q;
		end else begin
			push_cmd.rx_byte = rx_s1;
		end
	end

	// The buffer never holds more than one entry less than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUFFER_DEPTH - 1))
		else $error("receive buffer count out of range");

endmodule

// ===== hdl/sbx_queue.sv =====
// Short command queue that decouples the front end from the result sequencer.
module sbx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sbx_pkg::sbx_cmd_t  push_cmd,
	input  logic               pop,
	output sbx_pkg::sbx_cmd_t  head_cmd,
	output logic               head_valid,
	output sbx_pkg::sbx_qstat_t qstat
);
	import sbx_pkg::*;

	sbx_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head_cmd    = entry_q[rd_ptr_q];
	assign head_valid  = (count_q != '0);
	assign qstat.count = count_q;
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	// The front end's credit check must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && qstat.full |-> pop)
		else $error("command queue overflow");

	// The sequencer only retires a command that is present.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue underflow");

	// A push into an empty queue shows up at the head on the next cycle.
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		push && qstat.empty |=> head_valid)
		else $error("pushed command lost");

endmodule

// ===== hdl/sbx_back.sv =====
// Back end: expands each command into its result words and drives the output register.
module sbx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sbx_pkg::sbx_cmd_t head_cmd,
	input  logic              head_valid,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        drive_word,
	output logic              wait_after,
	output logic [7:0]        rx_byte,
	output logic              byte_stored,
	output logic [7:0]        fill_level,
	output logic              buffer_empty,
	output logic              last
);
	import sbx_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic               out_valid_q;
	logic               emit;
	logic               final_word;
	logic [2:0]         bit_sel;
	logic               tx_bit;
	logic [7:0]         word;
	logic               word_wait;

	// A new result enters the output register whenever it is free or being taken.
	assign emit       = head_valid && (!out_valid_q || !out_stall);
	assign final_word = (head_cmd.op == OP_POP) || (phase_q == LAST_PHASE);
	assign pop        = emit && final_word;

	// Bit phases go most significant bit first; each bit gives a low then a high clock word.
	assign bit_sel = 3'd7 - phase_q[3:1];
	assign tx_bit  = head_cmd.tx_byte[bit_sel];

	always_comb begin
		word      = 8'd0;
		word_wait = 1'b0;
		if (head_cmd.op == OP_EXCHANGE) begin
			if (phase_q[4]) begin
				word      = TERM_WORD[phase_q[1:0]];
				word_wait = TERM_WAIT[phase_q[1:0]];
			end else begin
				word[0]       = tx_bit;
				word[CLK_POS] = phase_q[0];
				word_wait     = 1'b1;
			end
		end
	end

	// Phase counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= '0;
			end else if (emit) begin
				phase_q <= phase_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (emit) begin
			drive_word   <= word;
			wait_after   <= word_wait;
			rx_byte      <= head_cmd.rx_byte;
			byte_stored  <= head_cmd.byte_stored;
			fill_level   <= head_cmd.fill_level;
			buffer_empty <= head_cmd.buffer_empty;
			last         <= final_word;
		end
	end

	assign out_valid = out_valid_q;

	// A sequence in progress always belongs to an exchange at the queue head.
	a_phase_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != '0) |-> head_valid && (head_cmd.op == OP_EXCHANGE))
		else $error("result sequence without an exchange command");

endmodule

// ===== hdl/serial_byte_exchange_rx_buffer_core.sv =====
// Top level of the serial byte exchange with receive buffer.
// An exchange item yields twenty result transfers: sixteen bit-phase drive words (low then
// high clock phase for each bit, most significant bit first) and four terminate words; a
// pop item yields one transfer carrying the oldest buffered byte. The output sequencer emits
// one result per cycle unless out_stall holds it. Input items are taken back to back while
// the four-entry command queue has room; the first result of an item passes through stage 1
// (beside the registered read of the receive buffer memory), then the command queue and the
// output register. A received byte is stored when the partner-ready sample is high, the byte
// is nonzero or zero bytes are enabled, and the buffer holds fewer than BUFFER_DEPTH-1 bytes.
// No clearing pass is needed after reset.
module serial_byte_exchange_rx_buffer_core #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] tx_byte,
	input  logic       partner_ready_sample,
	input  logic [7:0] line_samples,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] drive_word,
	output logic       wait_after,
	output logic [7:0] rx_byte,
	output logic       byte_stored,
	output logic [7:0] fill_level,
	output logic       buffer_empty,
	output logic       last
);
	import sbx_pkg::*;

	logic       push;
	sbx_cmd_t   push_cmd;
	logic       pop;
	sbx_cmd_t   head_cmd;
	logic       head_valid;
	sbx_qstat_t qstat;

	// Item intake and receive buffer.
	sbx_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.op                  (op),
		.tx_byte             (tx_byte),
		.partner_ready_sample(partner_ready_sample),
		.line_samples        (line_samples),
		.qstat               (qstat),
		.push                (push),
		.push_cmd            (push_cmd)
	);

	// Command queue.
	sbx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head_cmd  (head_cmd),
		.head_valid(head_valid),
		.qstat     (qstat)
	);

	// Result sequencer and output register.
	sbx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_cmd    (head_cmd),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.drive_word  (drive_word),
		.wait_after  (wait_after),
		.rx_byte     (rx_byte),
		.byte_stored (byte_stored),
		.fill_level  (fill_level),
		.buffer_empty(buffer_empty),
		.last        (last)
	);

endmodule
